@@ rtl/fvc_pkg.sv @@
// Types, constants and color wheel table shared by the flow color coder.
package fvc_pkg;

    localparam int FLOW_BITS     = 16;
    localparam int WHEEL_ENTRIES = 55;
    localparam int CORDIC_STEPS  = 30;
    localparam int CFG_BITS      = 15;
    localparam int RADIUS_BITS   = 16;
    localparam int ANGLE_BITS    = 32;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_MEASURE  = 2'd1,
        OP_COLORIZE = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_NORM      = 2'd1;

    typedef struct packed {
        op_t                         op;
        logic signed [FLOW_BITS-1:0] flow_x;
        logic signed [FLOW_BITS-1:0] flow_y;
        logic                        flow_missing;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [4:0] idx;
    } cordic_ctrl_t;

    typedef logic [WHEEL_ENTRIES-1:0][23:0] wheel_t;

    function automatic wheel_t build_wheel();
        wheel_t w;
        int     k;
        w = '0;
        k = 0;
        for (int i = 0; i < 15; i++)
        begin
            w[k] = {8'd255, 8'(255 * i / 15), 8'd0};
            k++;
        end
        for (int i = 0; i < 6; i++)
        begin
            w[k] = {8'(255 - 255 * i / 6), 8'd255, 8'd0};
            k++;
        end
        for (int i = 0; i < 4; i++)
        begin
            w[k] = {8'd0, 8'd255, 8'(255 * i / 4)};
            k++;
        end
        for (int i = 0; i < 11; i++)
        begin
            w[k] = {8'd0, 8'(255 - 255 * i / 11), 8'd255};
            k++;
        end
        for (int i = 0; i < 13; i++)
        begin
            w[k] = {8'(255 * i / 13), 8'd0, 8'd255};
            k++;
        end
        for (int i = 0; i < 6; i++)
        begin
            w[k] = {8'd255, 8'd0, 8'(255 - 255 * i / 6)};
            k++;
        end
        return w;
    endfunction

    localparam wheel_t WHEEL = build_wheel();

    function automatic logic [ANGLE_BITS-1:0] atan_turn(input logic [4:0] i);
        logic [ANGLE_BITS-1:0] a;
        case (i)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000029;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000003;
            5'd29:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/fvc_cordic.sv @@
// Vectoring CORDIC that turns a flow vector into a binary angle, one step per cycle in which ctrl.step is set.
module fvc_cordic
    import fvc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cordic_ctrl_t                ctrl,
    input  logic signed [FLOW_BITS-1:0] flow_x,
    input  logic signed [FLOW_BITS-1:0] flow_y,
    output logic [ANGLE_BITS-1:0]       angle
);

    localparam int CW = FLOW_BITS + 16;

    logic signed [CW-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [CW-1:0]   xe, ye, dx, dy;
    logic [ANGLE_BITS-1:0]  th_reg, th_next;
    logic                   run_reg, run_next;

    always_comb
    begin
        xe       = CW'(flow_x);
        ye       = CW'(flow_y);
        dx       = y_reg >>> ctrl.idx;
        dy       = x_reg >>> ctrl.idx;
        x_next   = x_reg;
        y_next   = y_reg;
        th_next  = th_reg;
        run_next = run_reg;
        if (ctrl.load)
        begin
            run_next = 1'b0;
            if (flow_y == '0)
            begin
                th_next = (flow_x >= 0) ? 32'h00000000 : 32'h80000000;
            end
            else if (flow_x == '0)
            begin
                th_next = (flow_y > 0) ? 32'h40000000 : 32'hC0000000;
            end
            else if (flow_x < 0)
            begin
                run_next = 1'b1;
                x_next   = (-xe) <<< 14;
                y_next   = (-ye) <<< 14;
                th_next  = 32'h80000000;
            end
            else
            begin
                run_next = 1'b1;
                x_next   = xe <<< 14;
                y_next   = ye <<< 14;
                th_next  = 32'h00000000;
            end
        end
        else if (ctrl.step && run_reg)
        begin
            if (y_reg > 0)
            begin
                x_next  = x_reg + dx;
                y_next  = y_reg - dy;
                th_next = th_reg + atan_turn(ctrl.idx);
            end
            else
            begin
                x_next  = x_reg - dx;
                y_next  = y_reg + dy;
                th_next = th_reg - atan_turn(ctrl.idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        y_reg  <= y_next;
        th_reg <= th_next;
    end

    assign angle = th_reg;

endmodule

@@ rtl/flow_vector_color_coder_core.sv @@
// Top level of the optical flow color coder: sequencer, root, divide and color datapath.
//
// Usage: items enter on in_valid/in_ready as in_item (op, flow_x, flow_y, flow_missing).
// A clear item resets the running maximum radius in its accept cycle. A measure item
// updates the maximum from a known vector and yields no result. A colorize item yields
// one out_item (red, green, blue) on out_valid/out_ready; unknown vectors give black.
// Registers are written on cfg_valid/cfg_ready by cfg_index and cfg_data at any time;
// cfg_ready is always high.
// A known colorize item inside the normalization radius passes from accept through the
// setup states PREP and SUM, the digit-serial square root (the CORDIC angle steps run
// alongside it), the radix-2 divider, the wheel position state, the color phases of the
// three channels and the output load; outside the radius the divider is skipped. An
// unknown colorize item goes straight to the output load. in_ready is high only while
// the sequencer is idle, so no new item is taken until the current one is through;
// clear, unused ops and unknown measures leave the sequencer idle.
// A stalled receiver holds the result in the output register; a following colorize
// item is then processed and waits before the output load until the register frees.
// Reset clears the sequencer, the output valid, the maximum radius and sets the
// registers to threshold 32767 and override 0.
module flow_vector_color_coder_core
    import fvc_pkg::*;
#(
    parameter int FRACTION_BITS = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int ITER = (FLOW_BITS + 16 > CORDIC_STEPS) ? FLOW_BITS + 16 : CORDIC_STEPS;
    localparam int RW   = 2 * ITER;
    localparam int SW   = 2 * FLOW_BITS;
    localparam int NW   = RADIUS_BITS + 1;
    localparam int CMPW = (SW > 2 * NW) ? SW : 2 * NW;
    localparam int CNTW = $clog2(ITER);
    localparam int KW   = $clog2(WHEEL_ENTRIES);
    localparam int PW   = ANGLE_BITS + KW;
    localparam logic [23:0] FULL_SCALE = 24'(255 * 65536);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PREP  = 8'b0000_0010,
        ST_SUM   = 8'b0000_0100,
        ST_ROOT  = 8'b0000_1000,
        ST_DIV   = 8'b0001_0000,
        ST_WPOS  = 8'b0010_0000,
        ST_COLOR = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t                      state_reg, state_next;
    op_t                         op_reg, op_next;
    logic signed [FLOW_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic [CFG_BITS-1:0]         thr_reg, thr_next, norm_reg, norm_next;
    logic [RADIUS_BITS-1:0]      max_reg, max_next;
    logic [SW-1:0]               sqx_reg, sqx_next, sqy_reg, sqy_next, s_sum;
    logic [2*NW-1:0]             nn_reg, nn_next;
    logic [NW-1:0]               n_reg, n_next, n_sel;
    logic                        inside_reg, inside_next;
    logic [RW-1:0]               rad_reg, rad_next;
    logic [ITER+1:0]             rem_reg, rem_next;
    logic [ITER+3:0]             rem_sh, trial;
    logic [ITER-1:0]             root_reg, root_next, root_step;
    logic [CNTW-1:0]             cnt_reg, cnt_next;
    logic [NW:0]                 drem_reg, drem_next, dsh;
    logic [ITER-1:0]             dvd_reg, dvd_next, quo_reg, quo_next, quo_step;
    logic [16:0]                 rn_reg, rn_next;
    logic [PW-1:0]               p_reg, p_next;
    logic [KW-1:0]               k0, k1;
    logic [15:0]                 frac;
    logic [24:0]                 prod_reg, prod_next;
    logic [23:0]                 v_reg, v_next, v_fin, w_sum;
    logic [40:0]                 blend;
    logic [25:0]                 dim;
    logic [1:0]                  ch_reg, ch_next, ph_reg, ph_next;
    logic [2:0][7:0]             rgb_reg, rgb_next;
    logic [7:0]                  w0, w1;
    logic                        out_valid_reg, out_valid_next;
    out_item_t                   out_item_reg, out_item_next;
    logic [FLOW_BITS-1:0]        in_mag_x, in_mag_y, mag_x, mag_y;
    logic                        in_unknown, out_free, root_last;
    logic [ITER-1:0]             radius_sat;
    logic [ANGLE_BITS-1:0]       angle;
    cordic_ctrl_t                cordic_ctrl;

    fvc_cordic u_cordic
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cordic_ctrl),
        .flow_x (x_reg),
        .flow_y (y_reg),
        .angle  (angle)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        in_mag_x   = in_item.flow_x[FLOW_BITS-1] ? -in_item.flow_x : in_item.flow_x;
        in_mag_y   = in_item.flow_y[FLOW_BITS-1] ? -in_item.flow_y : in_item.flow_y;
        in_unknown = in_item.flow_missing
                     || (in_mag_x > FLOW_BITS'(thr_reg)) || (in_mag_y > FLOW_BITS'(thr_reg));
        mag_x      = x_reg[FLOW_BITS-1] ? -x_reg : x_reg;
        mag_y      = y_reg[FLOW_BITS-1] ? -y_reg : y_reg;
        s_sum      = sqx_reg + sqy_reg;
        n_sel      = (norm_reg != '0) ? NW'(norm_reg) : NW'(max_reg);
        if (n_sel == '0)
        begin
            n_sel = NW'(1) << FRACTION_BITS;
        end

        rem_sh    = {rem_reg, rad_reg[RW-1 -: 2]};
        trial     = (ITER+4)'({root_reg, 2'b01});
        root_last = (cnt_reg == CNTW'(ITER - 1));
        if (rem_sh >= trial)
        begin
            root_step = {root_reg[ITER-2:0], 1'b1};
        end
        else
        begin
            root_step = {root_reg[ITER-2:0], 1'b0};
        end
        radius_sat = (root_step > ITER'(16'hFFFF)) ? ITER'(16'hFFFF) : root_step;

        dsh = {drem_reg[NW-1:0], dvd_reg[ITER-1]};
        quo_step = {quo_reg[ITER-2:0], (dsh >= {1'b0, n_reg})};

        k0 = p_reg[PW-1 -: KW];
        if (k0 >= KW'(WHEEL_ENTRIES))
        begin
            k0 = KW'(WHEEL_ENTRIES - 1);
        end
        k1    = (k0 == KW'(WHEEL_ENTRIES - 1)) ? '0 : k0 + KW'(1);
        frac  = p_reg[31:16];
        w0    = WHEEL[k0][23 - 8 * ch_reg -: 8];
        w1    = WHEEL[k1][23 - 8 * ch_reg -: 8];
        w_sum = 24'(prod_reg + 25'(frac * w1));
        blend = rn_reg * (FULL_SCALE - v_reg);
        dim   = (26'(v_reg) * 26'd3) >> 2;
        v_fin = inside_reg ? FULL_SCALE - blend[39:16] : dim[23:0];

        state_next     = state_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        thr_next       = thr_reg;
        norm_next      = norm_reg;
        max_next       = max_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        nn_next        = nn_reg;
        n_next         = n_reg;
        inside_next    = inside_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        cnt_next       = cnt_reg;
        drem_next      = drem_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        rn_next        = rn_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        v_next         = v_reg;
        ch_next        = ch_reg;
        ph_next        = ph_reg;
        rgb_next       = rgb_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cordic_ctrl    = '{load: 1'b0, step: 1'b0, idx: cnt_reg[4:0]};

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_next  = cfg_data[CFG_BITS-1:0];
                REG_NORM:      norm_next = cfg_data[CFG_BITS-1:0];
                default:       thr_next  = thr_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = in_item.op;
                    x_next  = in_item.flow_x;
                    y_next  = in_item.flow_y;
                    case (in_item.op)
                        OP_CLEAR:
                        begin
                            max_next = '0;
                        end
                        OP_MEASURE:
                        begin
                            if (!in_unknown)
                            begin
                                state_next = ST_PREP;
                            end
                        end
                        OP_COLORIZE:
                        begin
                            if (in_unknown)
                            begin
                                rgb_next   = '0;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_PREP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PREP:
            begin
                sqx_next         = SW'(mag_x * mag_x);
                sqy_next         = SW'(mag_y * mag_y);
                n_next           = n_sel;
                nn_next          = n_sel * n_sel;
                cordic_ctrl.load = 1'b1;
                state_next       = ST_SUM;
            end
            ST_SUM:
            begin
                inside_next = CMPW'(s_sum) <= CMPW'(nn_reg);
                rad_next    = (op_reg == OP_MEASURE) ? RW'(s_sum) : RW'(s_sum) << 32;
                rem_next    = '0;
                root_next   = '0;
                cnt_next    = '0;
                state_next  = ST_ROOT;
            end
            ST_ROOT:
            begin
                cordic_ctrl.step = (cnt_reg < CNTW'(CORDIC_STEPS));
                rem_next  = (rem_sh >= trial) ? (ITER+2)'(rem_sh - trial) : rem_sh[ITER+1:0];
                root_next = root_step;
                rad_next  = rad_reg << 2;
                cnt_next  = cnt_reg + CNTW'(1);
                if (root_last)
                begin
                    cnt_next = '0;
                    if (op_reg == OP_MEASURE)
                    begin
                        if (radius_sat[RADIUS_BITS-1:0] > max_reg)
                        begin
                            max_next = radius_sat[RADIUS_BITS-1:0];
                        end
                        state_next = ST_IDLE;
                    end
                    else if (inside_reg)
                    begin
                        drem_next  = '0;
                        dvd_next   = root_step;
                        quo_next   = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        rn_next    = '0;
                        state_next = ST_WPOS;
                    end
                end
            end
            ST_DIV:
            begin
                drem_next = quo_step[0] ? dsh - {1'b0, n_reg} : dsh;
                dvd_next  = dvd_reg << 1;
                quo_next  = quo_step;
                cnt_next  = cnt_reg + CNTW'(1);
                if (root_last)
                begin
                    cnt_next   = '0;
                    rn_next    = (quo_step > ITER'(65536)) ? 17'd65536 : quo_step[16:0];
                    state_next = ST_WPOS;
                end
            end
            ST_WPOS:
            begin
                p_next     = PW'(angle * KW'(WHEEL_ENTRIES - 1));
                ch_next    = '0;
                ph_next    = '0;
                state_next = ST_COLOR;
            end
            ST_COLOR:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        prod_next = (25'(17'd65536 - 17'(frac))) * 25'(w0);
                        ph_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        v_next  = w_sum;
                        ph_next = 2'd2;
                    end
                    default:
                    begin
                        rgb_next[2'd2 - ch_reg] = v_fin[23:16];
                        ph_next = 2'd0;
                        ch_next = ch_reg + 2'd1;
                        if (ch_reg == 2'd2)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_item_next  = '{red: rgb_reg[2], green: rgb_reg[1], blue: rgb_reg[0]};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            thr_reg       <= CFG_BITS'(32767);
            norm_reg      <= '0;
            max_reg       <= '0;
            cnt_reg       <= '0;
            ch_reg        <= '0;
            ph_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            thr_reg       <= thr_next;
            norm_reg      <= norm_next;
            max_reg       <= max_next;
            cnt_reg       <= cnt_next;
            ch_reg        <= ch_next;
            ph_reg        <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        nn_reg       <= nn_next;
        n_reg        <= n_next;
        inside_reg   <= inside_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        drem_reg     <= drem_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        rn_reg       <= rn_next;
        p_reg        <= p_next;
        prod_reg     <= prod_next;
        v_reg        <= v_next;
        rgb_reg      <= rgb_next;
        out_item_reg <= out_item_next;
    end

endmodule
